// ===== rtl/fdnr_pkg.sv =====
package fdnr_pkg;

   // configuration port
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 47;
   localparam int CFG_COUNT      = 8;

   // line settings layout
   localparam int DELAY_BITS = 14;
   localparam int GAIN_LSB   = 14;
   localparam int COEF_LSB   = 30;
   localparam int COEF_BITS  = 16;
   localparam int ENABLE_BIT = 46;

   // Q0.16 scaling
   localparam int FRAC_BITS = 16;
   localparam int FRAC_HALF = 32768;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_READ  = 6'b000010,
      ST_DIVGO = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_UPD   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

endpackage

// ===== rtl/feedback_delay_network_reverb_top.sv =====
// Late reverb: eight-line feedback delay network with Householder mixing.
//
// Request channel (req_valid / req_stall / req_sample) takes one mono sample;
// result channel (rsp_valid / rsp_stall / rsp_left / rsp_right) returns one
// stereo pair per request, in order. A request is taken only while the core
// is idle; the finished pair sits in an output register, so the next request
// is taken while the receiver still stalls the previous pair.
// Each request passes through the delay-memory reads of all lines, the scaling
// of the mix and both outputs, the five-stage per-line update pipeline and the
// load of the output register; the next request is taken only after that load.
// A request with the network disabled goes straight to the output state,
// returns zeros and touches no network state. A stalled receiver holds the
// core in its output state until the pair is taken.
// The csr port writes line settings; the user must write them only while the
// core is idle, which the block itself does not enforce. Any write to a valid
// index empties the network. Reset clears all settings, so the network starts
// disabled; empty delay entries are tracked by a fill count instead of a
// clearing pass, so the core is ready right after reset.
module feedback_delay_network_reverb_top import fdnr_pkg::*; #(
   parameter int LINES       = 8,
   parameter int LINE_DEPTH  = 16384,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_left,
   output logic signed [SAMPLE_BITS-1:0] rsp_right,
   input  logic                          csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   localparam int SB    = SAMPLE_BITS;
   localparam int LW    = $clog2(LINES);
   localparam int CW    = LW + 1;
   localparam int IW    = $clog2(LINE_DEPTH);
   localparam int AW    = LW + IW;
   localparam int SUM_W = SB + LW;
   localparam int NW    = SB + LW + 5;
   localparam int QW    = SB + 3;
   localparam int MW    = SB + 4;
   localparam int PAW   = MW + 18;
   localparam int PBW   = SB + 17;
   localparam int PSW   = SB + 23;
   localparam int FPW   = SB + 17;
   localparam int SMAX  = 2 ** (SB - 1) - 1;
   localparam int SMIN  = -SMAX - 1;
   localparam logic [NW:0]          NUM_OFFS = (NW + 1)'(2 * LINES) << (SB + 1);
   localparam logic signed [QW-1:0] Q_OFFS   = QW'(1) << (SB + 1);

   // settings and control
   logic [DELAY_BITS-1:0] dly_ff  [LINES];
   logic [DELAY_BITS-1:0] dly_in  [LINES];
   logic [COEF_BITS-1:0]  gain_ff [LINES];
   logic [COEF_BITS-1:0]  gain_in [LINES];
   logic [COEF_BITS-1:0]  coef_ff [LINES];
   logic [COEF_BITS-1:0]  coef_in [LINES];
   logic                  en_ff, en_in;
   state_type             state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [IW-1:0]         wp_ff, wp_in;
   logic [IW:0]           fill_ff, fill_in;
   logic [LINES-1:0]      dvld_ff, dvld_in;
   logic                  zero_ff, zero_in;
   logic signed [SB-1:0]  x_ff, x_in;

   // read phase
   logic                    rd_vld_ff, rd_vld_in;
   logic [LW-1:0]           rd_line_ff, rd_line_in;
   logic                    rd_ok_ff, rd_ok_in;
   logic signed [SB-1:0]    reads_ff [LINES];
   logic signed [SB-1:0]    reads_in [LINES];
   logic signed [SUM_W-1:0] sum_ff, sum_in, lsum_ff, lsum_in, rsum_ff, rsum_in;

   // update pipeline
   logic                  s1_vld_ff, s1_vld_in, s2_vld_ff, s2_vld_in;
   logic                  s3_vld_ff, s3_vld_in, s4_vld_ff, s4_vld_in;
   logic [LW-1:0]         s1_line_ff, s1_line_in, s2_line_ff, s2_line_in;
   logic [LW-1:0]         s3_line_ff, s3_line_in, s4_line_ff, s4_line_in;
   logic                  s1_dok_ff, s1_dok_in;
   logic signed [MW-1:0]  s1_mixed_ff, s1_mixed_in;
   logic signed [PAW-1:0] prod_a_ff, prod_a_in;
   logic signed [PBW-1:0] prod_b_ff, prod_b_in;
   logic signed [SB-1:0]  damped_ff, damped_in;
   logic signed [FPW-1:0] fbp_ff, fbp_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0] rsp_left_ff, rsp_left_in, rsp_right_ff, rsp_right_in;

   // memories and dividers
   logic            dl_wr_en, dl_rd_en, dm_wr_en, dm_rd_en;
   logic [AW-1:0]   dl_wr_addr, dl_rd_addr;
   logic [LW-1:0]   dm_wr_addr, dm_rd_addr;
   logic [SB-1:0]   dl_wr_data, dl_rd_data, dm_wr_data, dm_rd_data;
   logic            div_start, c_done, l_done, r_done;
   logic [NW-1:0]   c_num, l_num, r_num, c_quo, l_quo, r_quo;

   // per-line combinational terms
   logic [LW-1:0]          cnt_line;
   logic [IW-1:0]          d_cl, rd_idx;
   logic [IW:0]            t_idx;
   logic signed [SB-1:0]   rd_val, y_val, wr_val;
   logic signed [QW-1:0]   corr_q, left_q, right_q;
   logic [COEF_BITS:0]     oma;
   logic signed [PSW-1:0]  psum, psh;
   logic signed [FPW-1:0]  fbr;
   logic signed [SB+1:0]   wsum;
   logic                   out_free;

   fdnr_ram #(.WIDTH(SB), .DEPTH(LINES * (2 ** IW))) u_delay_ram (
      .clock   (clock),
      .wr_en   (dl_wr_en),
      .wr_addr (dl_wr_addr),
      .wr_data (dl_wr_data),
      .rd_en   (dl_rd_en),
      .rd_addr (dl_rd_addr),
      .rd_data (dl_rd_data)
   );

   fdnr_ram #(.WIDTH(SB), .DEPTH(LINES)) u_damper_ram (
      .clock   (clock),
      .wr_en   (dm_wr_en),
      .wr_addr (dm_wr_addr),
      .wr_data (dm_wr_data),
      .rd_en   (dm_rd_en),
      .rd_addr (dm_rd_addr),
      .rd_data (dm_rd_data)
   );

   // round(2*s/LINES) = floor((4s + LINES) / (2*LINES)), offset to stay positive
   function automatic logic [NW-1:0] div_numer(input logic signed [SUM_W-1:0] s);
      logic signed [NW:0] v;
      v = ((NW + 1)'(s) <<< 2) + (NW + 1)'(LINES) + $signed(NUM_OFFS);
      return v[NW-1:0];
   endfunction

   function automatic logic signed [QW-1:0] div_quot(input logic [NW-1:0] q);
      return $signed({1'b0, q[SB+1:0]}) - Q_OFFS;
   endfunction

   function automatic logic signed [SB-1:0] sat_q(input logic signed [QW-1:0] v);
      if (v > QW'(SMAX)) begin
         return SB'(SMAX);
      end else if (v < QW'(SMIN)) begin
         return SB'(SMIN);
      end
      return SB'(v);
   endfunction

   assign c_num = div_numer(sum_ff);
   assign l_num = div_numer(lsum_ff);
   assign r_num = div_numer(rsum_ff);
   assign div_start = (state_ff == ST_DIVGO);

   fdnr_div #(.NUM_BITS(NW), .DIVISOR(2 * LINES)) u_div_corr (
      .clock (clock), .reset (reset), .start (div_start),
      .numer (c_num), .done (c_done), .quo (c_quo)
   );

   fdnr_div #(.NUM_BITS(NW), .DIVISOR(2 * LINES)) u_div_left (
      .clock (clock), .reset (reset), .start (div_start),
      .numer (l_num), .done (l_done), .quo (l_quo)
   );

   fdnr_div #(.NUM_BITS(NW), .DIVISOR(2 * LINES)) u_div_right (
      .clock (clock), .reset (reset), .start (div_start),
      .numer (r_num), .done (r_done), .quo (r_quo)
   );

   assign corr_q  = div_quot(c_quo);
   assign left_q  = div_quot(l_quo);
   assign right_q = div_quot(r_quo);

   // read address for the line under the counter: wp - d - 1, wrapped
   assign cnt_line = cnt_ff[LW-1:0];
   always_comb begin
      if (32'(dly_ff[cnt_line]) > LINE_DEPTH - 1) begin
         d_cl = IW'(LINE_DEPTH - 1);
      end else begin
         d_cl = IW'(dly_ff[cnt_line]);
      end
      t_idx = {1'b0, wp_ff} - {1'b0, d_cl} - (IW + 1)'(1);
      if (t_idx[IW]) begin
         rd_idx = IW'(t_idx + (IW + 1)'(LINE_DEPTH));
      end else begin
         rd_idx = t_idx[IW-1:0];
      end
   end

   assign dl_rd_en   = (state_ff == ST_READ) && (cnt_ff < CW'(LINES));
   assign dl_rd_addr = {cnt_line, rd_idx};
   assign dm_rd_en   = (state_ff == ST_UPD) && (cnt_ff < CW'(LINES));
   assign dm_rd_addr = cnt_line;

   // entries not yet written since the last clear read as zero
   assign rd_val = rd_ok_ff ? $signed(dl_rd_data) : '0;
   assign y_val  = s1_dok_ff ? $signed(dm_rd_data) : '0;
   assign oma    = (COEF_BITS + 1)'(2 ** FRAC_BITS) - {1'b0, coef_ff[s1_line_ff]};

   // damper: round(((1-a)x + a*y) / 2^16), saturated
   always_comb begin
      psum = PSW'(prod_a_ff) + PSW'(prod_b_ff) + PSW'(FRAC_HALF);
      psh  = psum >>> FRAC_BITS;
      if (psh > PSW'(SMAX)) begin
         damped_in = SB'(SMAX);
      end else if (psh < PSW'(SMIN)) begin
         damped_in = SB'(SMIN);
      end else begin
         damped_in = SB'(psh);
      end
   end

   // feedback: round(damped*gain / 2^16) plus input, saturated
   always_comb begin
      fbr  = (fbp_ff + FPW'(FRAC_HALF)) >>> FRAC_BITS;
      wsum = (SB + 2)'(x_ff) + (SB + 2)'(fbr);
      if (wsum > (SB + 2)'(SMAX)) begin
         wr_val = SB'(SMAX);
      end else if (wsum < (SB + 2)'(SMIN)) begin
         wr_val = SB'(SMIN);
      end else begin
         wr_val = SB'(wsum);
      end
   end

   assign dm_wr_en   = s2_vld_ff;
   assign dm_wr_addr = s2_line_ff;
   assign dm_wr_data = damped_in;
   assign dl_wr_en   = s4_vld_ff;
   assign dl_wr_addr = {s4_line_ff, wp_ff};
   assign dl_wr_data = wr_val;

   assign prod_a_in = PAW'($signed({1'b0, oma})) * PAW'(s1_mixed_ff);
   assign prod_b_in = PBW'($signed({1'b0, coef_ff[s1_line_ff]})) * PBW'(y_val);
   assign fbp_in    = FPW'($signed({1'b0, gain_ff[s3_line_ff]})) * FPW'(damped_ff);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      dly_in       = dly_ff;
      gain_in      = gain_ff;
      coef_in      = coef_ff;
      en_in        = en_ff;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      dvld_in      = dvld_ff;
      zero_in      = zero_ff;
      x_in         = x_ff;
      reads_in     = reads_ff;
      sum_in       = sum_ff;
      lsum_in      = lsum_ff;
      rsum_in      = rsum_ff;
      rd_vld_in    = dl_rd_en;
      rd_line_in   = cnt_line;
      rd_ok_in     = ({1'b0, d_cl} + (IW + 1)'(1)) <= fill_ff;
      s1_vld_in    = dm_rd_en;
      s1_line_in   = cnt_line;
      s1_dok_in    = dvld_ff[cnt_line];
      s1_mixed_in  = MW'(reads_ff[cnt_line]) - MW'(corr_q);
      s2_vld_in    = s1_vld_ff;
      s2_line_in   = s1_line_ff;
      s3_vld_in    = s2_vld_ff;
      s3_line_in   = s2_line_ff;
      s4_vld_in    = s3_vld_ff;
      s4_line_in   = s3_line_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in    = req_sample;
               cnt_in  = '0;
               sum_in  = '0;
               lsum_in = '0;
               rsum_in = '0;
               zero_in = !en_ff;
               state_in = en_ff ? ST_READ : ST_OUT;
            end
         end
         ST_READ: begin
            if (dl_rd_en) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               reads_in[rd_line_ff] = rd_val;
               sum_in = sum_ff + SUM_W'(rd_val);
               if (rd_line_ff[0]) begin
                  rsum_in = rsum_ff + SUM_W'(rd_val);
               end else begin
                  lsum_in = lsum_ff + SUM_W'(rd_val);
               end
               if (rd_line_ff == LW'(LINES - 1)) begin
                  state_in = ST_DIVGO;
               end
            end
         end
         ST_DIVGO: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (c_done && l_done && r_done) begin
               cnt_in   = '0;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (dm_rd_en) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (s2_vld_ff) begin
               dvld_in[s2_line_ff] = 1'b1;
            end
            // last line written: advance the shared write position
            if (s4_vld_ff && s4_line_ff == LW'(LINES - 1)) begin
               wp_in = (wp_ff == IW'(LINE_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
               if (fill_ff < (IW + 1)'(LINE_DEPTH)) begin
                  fill_in = fill_ff + 1'b1;
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = zero_ff ? '0 : sat_q(left_q);
               rsp_right_in = zero_ff ? '0 : sat_q(right_q);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // settings write: empty the network, then store the register
      if (csr_wr_en && csr_index < CSR_INDEX_BITS'(CFG_COUNT)) begin
         wp_in   = '0;
         fill_in = '0;
         dvld_in = '0;
         for (int k = 0; k < LINES; k++) begin
            if (k == int'(csr_index)) begin
               dly_in[k]  = csr_data[DELAY_BITS-1:0];
               gain_in[k] = csr_data[GAIN_LSB +: COEF_BITS];
               coef_in[k] = csr_data[COEF_LSB +: COEF_BITS];
            end
         end
         if (csr_index == '0) begin
            en_in = csr_data[ENABLE_BIT];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LINES; k++) begin
            dly_ff[k]  <= '0;
            gain_ff[k] <= '0;
            coef_ff[k] <= '0;
         end
         en_ff        <= 1'b0;
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         dvld_ff      <= '0;
         zero_ff      <= 1'b0;
         rd_vld_ff    <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         s4_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dly_ff       <= dly_in;
         gain_ff      <= gain_in;
         coef_ff      <= coef_in;
         en_ff        <= en_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         dvld_ff      <= dvld_in;
         zero_ff      <= zero_in;
         rd_vld_ff    <= rd_vld_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         s3_vld_ff    <= s3_vld_in;
         s4_vld_ff    <= s4_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff         <= x_in;
      reads_ff     <= reads_in;
      sum_ff       <= sum_in;
      lsum_ff      <= lsum_in;
      rsum_ff      <= rsum_in;
      rd_line_ff   <= rd_line_in;
      rd_ok_ff     <= rd_ok_in;
      s1_line_ff   <= s1_line_in;
      s1_dok_ff    <= s1_dok_in;
      s1_mixed_ff  <= s1_mixed_in;
      s2_line_ff   <= s2_line_in;
      s3_line_ff   <= s3_line_in;
      s4_line_ff   <= s4_line_in;
      prod_a_ff    <= prod_a_in;
      prod_b_ff    <= prod_b_in;
      damped_ff    <= damped_in;
      fbp_ff       <= fbp_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_left  = rsp_left_ff;
   assign rsp_right = rsp_right_ff;

endmodule

// ===== rtl/fdnr_ram.sv =====
module fdnr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fdnr_div.sv =====
module fdnr_div #(
   parameter int NUM_BITS = 24,
   parameter int DIVISOR  = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numer,
   output logic                done,
   output logic [NUM_BITS-1:0] quo
);

   // floor(n / DIVISOR) = (n * RECIP) >> SHIFT, exact for every NUM_BITS-bit n
   localparam int SHIFT = NUM_BITS + $clog2(DIVISOR);
   localparam int RB    = NUM_BITS + 2;
   localparam int PW    = NUM_BITS + RB;
   localparam logic [RB-1:0] RECIP = RB'((64'd1 << SHIFT) / 64'(DIVISOR) + 64'd1);

   logic [PW-1:0]       prod;
   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic                done_ff;

   assign prod   = PW'(numer) * PW'(RECIP);
   // hold the quotient until the next start
   assign quo_in = start ? NUM_BITS'(prod >> SHIFT) : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule
